### rtl/mer_pkg.sv
// Shared constants and types for the midpoint ellipse rasterizer.
// No dependencies; every other file in rtl/ refers to this package.
`timescale 1ns / 1ps

package mer_pkg;

  // Default semi-axis width; the top level hands it down as RADIUS_BITS.
  localparam int RADIUS_BITS_DEF = 10;

  localparam int CENTER_W   = 11;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 2;
  // Wide enough for the largest legal RADIUS_BITS.
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd3;

  // Cycles the setup products need to settle after a register write or reset.
  localparam int SETTLE_CYCLES = 3;
  localparam int SETTLE_W      = 2;

  // One step's outcome, from the step datapath to the result register.
  typedef struct packed {
    logic                       present;
    logic signed [COORD_W-1:0]  right_x;
    logic signed [COORD_W-1:0]  left_x;
    logic signed [COORD_W-1:0]  upper_y;
    logic signed [COORD_W-1:0]  lower_y;
    logic                       region;
    logic                       last;
  } point_t;

endpackage

### rtl/mer_if.sv
// Channel interfaces of the midpoint ellipse rasterizer: step, result, config.
// Depends on mer_pkg for field widths.
`timescale 1ns / 1ps

interface mer_step_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mer_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [mer_pkg::COORD_W-1:0] right_x;
  logic signed [mer_pkg::COORD_W-1:0] left_x;
  logic signed [mer_pkg::COORD_W-1:0] upper_y;
  logic signed [mer_pkg::COORD_W-1:0] lower_y;
  logic                               region;
  logic                               last;

  modport source (output valid, output right_x, output left_x, output upper_y,
                  output lower_y, output region, output last, input ready);
  modport sink   (input valid, input right_x, input left_x, input upper_y,
                  input lower_y, input region, input last, output ready);
endinterface

interface mer_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mer_pkg::CFG_IDX_W-1:0]     index;
  logic [mer_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/midpoint_ellipse_rasterizer_unit.sv
// Midpoint ellipse rasterizer: at most one ellipse point per step transfer, as four
// mirrored coordinates. An item passes an input register and then the result
// register, and the unit takes one step per clock while results are taken:
// the walk state updates in the same cycle with adds only. After reset and
// after every config write the step channel holds ready low while the setup
// stages recompute the squared radii, rx^2*ry, ry^2*rx and the initial
// decision values. Config writes apply at the next restart. Depends on mer_pkg,
// mer_if, mer_setup and mer_step.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  mer_step_if.sink             step,
  mer_result_if.source         result,
  mer_cfg_if.sink              cfg
);

  localparam int SQ_W  = 2 * RADIUS_BITS;
  localparam int CU_W  = 3 * RADIUS_BITS;
  localparam int DEC_W = 4 * RADIUS_BITS;

  // config registers
  logic [RADIUS_BITS-1:0]               radius_x;
  logic [RADIUS_BITS-1:0]               radius_y;
  logic signed [mer_pkg::CENTER_W-1:0]  center_x;
  logic signed [mer_pkg::CENTER_W-1:0]  center_y;
  logic [mer_pkg::SETTLE_W-1:0]         settle;

  logic [RADIUS_BITS-1:0]  rx;
  logic [RADIUS_BITS-1:0]  ry;
  logic [SQ_W-1:0]         rx2;
  logic [SQ_W-1:0]         ry2;
  logic [CU_W-1:0]         rx2ry;
  logic [CU_W-1:0]         ry2rx;
  logic signed [DEC_W-1:0] dinit1;
  logic signed [DEC_W-1:0] dinit2;

  logic            in_valid;
  logic            in_restart;
  logic            advance;
  logic            settled;
  mer_pkg::point_t point;
  mer_pkg::point_t res_q;
  logic            res_valid;

  assign cfg.ready = 1'b1;
  assign settled   = (settle == '0);
  assign advance   = in_valid && settled && (!res_valid || result.ready);
  assign step.ready = settled && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x <= RADIUS_BITS'(1);
      radius_y <= RADIUS_BITS'(1);
      center_x <= '0;
      center_y <= '0;
      settle   <= mer_pkg::SETTLE_W'(mer_pkg::SETTLE_CYCLES);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mer_pkg::REG_RADIUS_X: radius_x <= cfg.data[RADIUS_BITS-1:0];
        mer_pkg::REG_RADIUS_Y: radius_y <= cfg.data[RADIUS_BITS-1:0];
        mer_pkg::REG_CENTER_X: center_x <= cfg.data[mer_pkg::CENTER_W-1:0];
        mer_pkg::REG_CENTER_Y: center_y <= cfg.data[mer_pkg::CENTER_W-1:0];
      endcase
      settle <= mer_pkg::SETTLE_W'(mer_pkg::SETTLE_CYCLES);
    end else if (!settled) begin
      settle <= settle - mer_pkg::SETTLE_W'(1);
    end
  end

  mer_setup #(.RADIUS_BITS(RADIUS_BITS)) u_setup (
    .clk      (clk),
    .radius_x (radius_x),
    .radius_y (radius_y),
    .rx       (rx),
    .ry       (ry),
    .rx2      (rx2),
    .ry2      (ry2),
    .rx2ry    (rx2ry),
    .ry2rx    (ry2rx),
    .dinit1   (dinit1),
    .dinit2   (dinit2)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (step.valid && step.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.ready) begin
      in_restart <= step.restart;
    end
  end

  mer_step #(.RADIUS_BITS(RADIUS_BITS)) u_step (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .restart    (in_restart),
    .cfg_rx     (rx),
    .cfg_ry     (ry),
    .cfg_rx2    (rx2),
    .cfg_ry2    (ry2),
    .cfg_rx2ry  (rx2ry),
    .cfg_ry2rx  (ry2rx),
    .cfg_dinit1 (dinit1),
    .cfg_dinit2 (dinit2),
    .cfg_cx     (center_x),
    .cfg_cy     (center_y),
    .point      (point)
  );

  // result register; a step after the last point produces no transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= point.present;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= point;
    end
  end

  assign result.valid   = res_valid;
  assign result.right_x = res_q.right_x;
  assign result.left_x  = res_q.left_x;
  assign result.upper_y = res_q.upper_y;
  assign result.lower_y = res_q.lower_y;
  assign result.region  = res_q.region;
  assign result.last    = res_q.last;

endmodule

### rtl/mer_setup.sv
// Per-ellipse constants: squared radii, cubic products and the two initial
// decision values, computed from the radius registers over three stages.
// Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_setup #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                            clk,
  input  logic [RADIUS_BITS-1:0]          radius_x,
  input  logic [RADIUS_BITS-1:0]          radius_y,
  output logic [RADIUS_BITS-1:0]          rx,
  output logic [RADIUS_BITS-1:0]          ry,
  output logic [2*RADIUS_BITS-1:0]        rx2,
  output logic [2*RADIUS_BITS-1:0]        ry2,
  output logic [3*RADIUS_BITS-1:0]        rx2ry,
  output logic [3*RADIUS_BITS-1:0]        ry2rx,
  output logic signed [4*RADIUS_BITS-1:0] dinit1,
  output logic signed [4*RADIUS_BITS-1:0] dinit2
);

  localparam int SQ_W  = 2 * RADIUS_BITS;
  localparam int CU_W  = 3 * RADIUS_BITS;
  localparam int DEC_W = 4 * RADIUS_BITS;

  logic [RADIUS_BITS-1:0] rx_eff;
  logic [RADIUS_BITS-1:0] ry_eff;
  logic signed [DEC_W-1:0] rx2_d;
  logic signed [DEC_W-1:0] ry2_d;
  logic signed [DEC_W-1:0] rx2ry_d;
  logic signed [DEC_W-1:0] ry2rx_d;

  // A zero radius is treated as one.
  assign rx_eff = (radius_x == '0) ? RADIUS_BITS'(1) : radius_x;
  assign ry_eff = (radius_y == '0) ? RADIUS_BITS'(1) : radius_y;

  assign rx2_d   = DEC_W'(rx2);
  assign ry2_d   = DEC_W'(ry2);
  assign rx2ry_d = DEC_W'(rx2ry);
  assign ry2rx_d = DEC_W'(ry2rx);

  always_ff @(posedge clk) begin
    rx    <= rx_eff;
    ry    <= ry_eff;
    rx2   <= SQ_W'(rx_eff) * SQ_W'(rx_eff);
    ry2   <= SQ_W'(ry_eff) * SQ_W'(ry_eff);
    rx2ry <= CU_W'(rx2) * CU_W'(ry);
    ry2rx <= CU_W'(ry2) * CU_W'(rx);
    // d1 = ry^2 - rx^2*ry + rx^2/4, d2 = rx^2 - rx*ry^2 + ry^2/4
    dinit1 <= ry2_d - rx2ry_d + (rx2_d >>> 2);
    dinit2 <= rx2_d - ry2rx_d + (ry2_d >>> 2);
  end

endmodule

### rtl/mer_step.sv
// Walk state and combinational step datapath of the midpoint ellipse walk.
// Products ry^2*x and rx^2*y are kept as running sums. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_step #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  logic                                 restart,
  input  logic [RADIUS_BITS-1:0]               cfg_rx,
  input  logic [RADIUS_BITS-1:0]               cfg_ry,
  input  logic [2*RADIUS_BITS-1:0]             cfg_rx2,
  input  logic [2*RADIUS_BITS-1:0]             cfg_ry2,
  input  logic [3*RADIUS_BITS-1:0]             cfg_rx2ry,
  input  logic [3*RADIUS_BITS-1:0]             cfg_ry2rx,
  input  logic signed [4*RADIUS_BITS-1:0]      cfg_dinit1,
  input  logic signed [4*RADIUS_BITS-1:0]      cfg_dinit2,
  input  logic signed [mer_pkg::CENTER_W-1:0]  cfg_cx,
  input  logic signed [mer_pkg::CENTER_W-1:0]  cfg_cy,
  output mer_pkg::point_t                      point
);

  localparam int SQ_W  = 2 * RADIUS_BITS;
  localparam int CU_W  = 3 * RADIUS_BITS;
  localparam int DEC_W = 4 * RADIUS_BITS;
  localparam int OFF_W = RADIUS_BITS + 2;
  localparam int P_W   = CU_W + 2;
  localparam int CW    = mer_pkg::COORD_W;

  localparam logic [1:0] PH_ONE  = 2'd0;
  localparam logic [1:0] PH_TWO  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // walk state
  logic [1:0]              phase;
  logic signed [OFF_W-1:0] off_x;
  logic signed [OFF_W-1:0] off_y;
  logic signed [P_W-1:0]   acc_a;    // ry^2 * off_x
  logic signed [P_W-1:0]   acc_b;    // rx^2 * off_y
  logic signed [DEC_W-1:0] decision;

  // constants latched at restart
  logic signed [mer_pkg::CENTER_W-1:0] use_cx;
  logic signed [mer_pkg::CENTER_W-1:0] use_cy;
  logic [RADIUS_BITS-1:0]  use_rx;
  logic [SQ_W-1:0]         use_rx2;
  logic [SQ_W-1:0]         use_ry2;
  logic [CU_W-1:0]         use_ry2rx;
  logic signed [DEC_W-1:0] use_dinit2;

  // selected for this step
  logic signed [mer_pkg::CENTER_W-1:0] sel_cx;
  logic signed [mer_pkg::CENTER_W-1:0] sel_cy;
  logic [RADIUS_BITS-1:0]  sel_rx;
  logic [SQ_W-1:0]         sel_rx2;
  logic [SQ_W-1:0]         sel_ry2;
  logic [CU_W-1:0]         sel_ry2rx;
  logic signed [DEC_W-1:0] sel_dinit2;
  logic signed [P_W-1:0]   rx2_p;
  logic signed [P_W-1:0]   ry2_p;

  logic [1:0]              cur_ph;
  logic signed [OFF_W-1:0] cur_x;
  logic signed [OFF_W-1:0] cur_y;
  logic signed [P_W-1:0]   cur_a;
  logic signed [P_W-1:0]   cur_b;
  logic signed [DEC_W-1:0] cur_d;

  logic [1:0]              phase_next;
  logic signed [OFF_W-1:0] off_x_next;
  logic signed [OFF_W-1:0] off_y_next;
  logic signed [P_W-1:0]   acc_a_next;
  logic signed [P_W-1:0]   acc_b_next;
  logic signed [DEC_W-1:0] decision_next;
  logic                    last_flag;
  logic                    nonneg;
  logic signed [DEC_W-1:0] d_sub;

  always_comb begin
    sel_cx     = restart ? cfg_cx     : use_cx;
    sel_cy     = restart ? cfg_cy     : use_cy;
    sel_rx     = restart ? cfg_rx     : use_rx;
    sel_rx2    = restart ? cfg_rx2    : use_rx2;
    sel_ry2    = restart ? cfg_ry2    : use_ry2;
    sel_ry2rx  = restart ? cfg_ry2rx  : use_ry2rx;
    sel_dinit2 = restart ? cfg_dinit2 : use_dinit2;
    rx2_p      = P_W'($signed({1'b0, sel_rx2}));
    ry2_p      = P_W'($signed({1'b0, sel_ry2}));

    if (restart) begin
      cur_ph = PH_ONE;
      cur_x  = '0;
      cur_y  = OFF_W'($signed({1'b0, cfg_ry}));
      cur_a  = '0;
      cur_b  = P_W'($signed({1'b0, cfg_rx2ry}));
      cur_d  = cfg_dinit1;
    end else begin
      cur_ph = phase;
      cur_x  = off_x;
      cur_y  = off_y;
      cur_a  = acc_a;
      cur_b  = acc_b;
      cur_d  = decision;
    end
  end

  always_comb begin
    nonneg        = ~cur_d[DEC_W-1];
    phase_next    = cur_ph;
    off_x_next    = cur_x;
    off_y_next    = cur_y;
    acc_a_next    = cur_a;
    acc_b_next    = cur_b;
    decision_next = cur_d;
    d_sub         = '0;
    last_flag     = 1'b0;
    unique case (cur_ph)
      PH_ONE: begin
        off_x_next = cur_x + OFF_W'(1);
        acc_a_next = cur_a + ry2_p;
        if (nonneg) begin
          off_y_next = cur_y - OFF_W'(1);
          acc_b_next = cur_b - rx2_p;
          d_sub      = DEC_W'(acc_b_next) <<< 1;
        end
        decision_next = cur_d - d_sub + DEC_W'(ry2_p) + (DEC_W'(acc_a_next) <<< 1);
        if (acc_a_next > acc_b_next) begin
          // slope passed -1: restart from (rx, 0) in region two
          phase_next    = PH_TWO;
          off_x_next    = OFF_W'($signed({1'b0, sel_rx}));
          off_y_next    = '0;
          acc_a_next    = P_W'($signed({1'b0, sel_ry2rx}));
          acc_b_next    = '0;
          decision_next = sel_dinit2;
        end
      end
      PH_TWO: begin
        off_y_next = cur_y + OFF_W'(1);
        acc_b_next = cur_b + rx2_p;
        if (nonneg) begin
          off_x_next = cur_x - OFF_W'(1);
          acc_a_next = cur_a - ry2_p;
          d_sub      = DEC_W'(acc_a_next) <<< 1;
        end
        decision_next = cur_d - d_sub + DEC_W'(rx2_p) + (DEC_W'(acc_b_next) <<< 1);
        if (!(acc_a_next > acc_b_next)) begin
          phase_next = PH_DONE;
          last_flag  = 1'b1;
        end
      end
      default: begin
        phase_next = cur_ph;
      end
    endcase
  end

  always_comb begin
    point.present = (cur_ph != PH_DONE);
    point.right_x = CW'(sel_cx) + CW'(cur_x);
    point.left_x  = CW'(sel_cx) - CW'(cur_x);
    point.upper_y = CW'(sel_cy) + CW'(cur_y);
    point.lower_y = CW'(sel_cy) - CW'(cur_y);
    point.region  = (cur_ph == PH_TWO);
    point.last    = last_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DONE;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      off_x    <= off_x_next;
      off_y    <= off_y_next;
      acc_a    <= acc_a_next;
      acc_b    <= acc_b_next;
      decision <= decision_next;
    end
    if (advance && restart) begin
      use_cx     <= cfg_cx;
      use_cy     <= cfg_cy;
      use_rx     <= cfg_rx;
      use_rx2    <= cfg_rx2;
      use_ry2    <= cfg_ry2;
      use_ry2rx  <= cfg_ry2rx;
      use_dinit2 <= cfg_dinit2;
    end
  end

endmodule

### rtl/mer_checker.sv
// Port-level assertions for midpoint_ellipse_rasterizer_unit and their bind.
// Depends on mer_pkg and the top level's interface ports.
`timescale 1ns / 1ps

module mer_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               step_ready,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic signed [mer_pkg::COORD_W-1:0] right_x,
  input logic signed [mer_pkg::COORD_W-1:0] left_x,
  input logic signed [mer_pkg::COORD_W-1:0] upper_y,
  input logic signed [mer_pkg::COORD_W-1:0] lower_y,
  input logic                               region,
  input logic                               last
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(right_x) && $stable(left_x)
      && $stable(upper_y) && $stable(lower_y) && $stable(region) && $stable(last))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // setup products are recomputed after a register write
  a_cfg_pause: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !step_ready)
    else $error("step taken while setup stages settle");

  // mirrored pairs sum to twice the center, so their low bits agree
  a_mirror: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (right_x[0] == left_x[0]) && (upper_y[0] == lower_y[0]))
    else $error("mirrored coordinates inconsistent");

  a_last_region: assert property (@(posedge clk) disable iff (rst)
    res_valid && last |-> region)
    else $error("final point flagged outside region two");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker u_mer_checker (
  .clk        (clk),
  .rst        (rst),
  .step_ready (step.ready),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .right_x    (result.right_x),
  .left_x     (result.left_x),
  .upper_y    (result.upper_y),
  .lower_y    (result.lower_y),
  .region     (result.region),
  .last       (result.last)
);

### test/ellipse_point_checker.sv
// Scoreboard for the midpoint ellipse rasterizer: keeps its own copy of the
// register file and the quadrant walk, predicts at most one point per step transfer
// and checks every result transfer. Depends on mer_pkg and the interfaces in mer_if.
`timescale 1ns / 1ps

module ellipse_point_checker
  import mer_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  mer_step_if   step,
  mer_result_if result,
  mer_cfg_if    cfg,
  output int    errors,
  output int    pending
);

  typedef enum logic [1:0] {WALK_ONE, WALK_TWO, WALK_DONE} walk_t;

  // register file as written
  logic [RADIUS_BITS_DEF-1:0] reg_rx, reg_ry;
  logic [CENTER_W-1:0]        reg_cx, reg_cy;

  // values latched at restart and the walk itself
  longint walk_rx, walk_ry, walk_cx, walk_cy;
  longint off_x, off_y, decision;
  walk_t  walk;

  point_t expected_points[$];
  int     mismatches = 0;

  function automatic void clear_model();
    reg_rx   = 1;
    reg_ry   = 1;
    reg_cx   = '0;
    reg_cy   = '0;
    walk_rx  = 1;
    walk_ry  = 1;
    walk_cx  = 0;
    walk_cy  = 0;
    off_x    = 0;
    off_y    = 0;
    decision = 0;
    walk     = WALK_DONE;
  endfunction

  function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_RADIUS_X: reg_rx = val[RADIUS_BITS_DEF-1:0];
      REG_RADIUS_Y: reg_ry = val[RADIUS_BITS_DEF-1:0];
      REG_CENTER_X: reg_cx = val[CENTER_W-1:0];
      REG_CENTER_Y: reg_cy = val[CENTER_W-1:0];
      default: ;
    endcase
  endfunction

  // One step of the walk; returns 1 when the step yields a point.
  function automatic bit next_ellipse_point(input logic restart, output point_t pt);
    longint rx2, ry2;
    pt = '0;
    if (restart) begin
      // a zero radius behaves as one
      walk_rx  = (reg_rx == 0) ? 1 : reg_rx;
      walk_ry  = (reg_ry == 0) ? 1 : reg_ry;
      walk_cx  = $signed(reg_cx);
      walk_cy  = $signed(reg_cy);
      rx2      = walk_rx * walk_rx;
      ry2      = walk_ry * walk_ry;
      off_x    = 0;
      off_y    = walk_ry;
      decision = ry2 - rx2 * walk_ry + rx2 / 4;
      walk     = WALK_ONE;
    end
    if (walk == WALK_DONE) return 1'b0;

    rx2        = walk_rx * walk_rx;
    ry2        = walk_ry * walk_ry;
    pt.present = 1'b1;
    pt.right_x = COORD_W'(walk_cx + off_x);
    pt.left_x  = COORD_W'(walk_cx - off_x);
    pt.upper_y = COORD_W'(walk_cy + off_y);
    pt.lower_y = COORD_W'(walk_cy - off_y);
    pt.region  = (walk == WALK_TWO);
    pt.last    = 1'b0;

    if (walk == WALK_ONE) begin
      off_x = off_x + 1;
      if (decision >= 0) begin
        off_y    = off_y - 1;
        decision = decision - 2 * rx2 * off_y;
      end
      decision = decision + ry2 * (1 + 2 * off_x);
      if (ry2 * off_x > rx2 * off_y) begin
        // switch to the steep part, starting from the x axis
        off_x    = walk_rx;
        off_y    = 0;
        decision = rx2 - walk_rx * ry2 + ry2 / 4;
        walk     = WALK_TWO;
      end
    end else begin
      off_y = off_y + 1;
      if (decision >= 0) begin
        off_x    = off_x - 1;
        decision = decision - 2 * ry2 * off_x;
      end
      decision = decision + rx2 * (1 + 2 * off_y);
      if (ry2 * off_x <= rx2 * off_y) begin
        walk    = WALK_DONE;
        pt.last = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name,
                                        input logic signed [COORD_W-1:0] want,
                                        input logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_point();
    point_t want;
    if (expected_points.size() == 0) begin
      mismatches++;
      $display("%0t: point with none expected: right_x %0d left_x %0d upper_y %0d lower_y %0d",
               $time, result.right_x, result.left_x, result.upper_y, result.lower_y);
      return;
    end
    want = expected_points.pop_front();
    compare_field("right_x", want.right_x, result.right_x);
    compare_field("left_x",  want.left_x,  result.left_x);
    compare_field("upper_y", want.upper_y, result.upper_y);
    compare_field("lower_y", want.lower_y, result.lower_y);
    compare_field("region",  want.region,  result.region);
    compare_field("last",    want.last,    result.last);
  endfunction

  always @(posedge clk) begin
    point_t pt;
    if (rst) begin
      clear_model();
      expected_points.delete();
    end else begin
      if (cfg.valid && cfg.ready) store_register(cfg.index, cfg.data);
      if (step.valid && step.ready && next_ellipse_point(step.restart, pt))
        expected_points.push_back(pt);
      if (result.valid && result.ready) check_point();
    end
    pending <= expected_points.size();
    errors  <= mismatches;
  end

endmodule

### test/testbench.sv
// Top of the ellipse rasterizer bench: clock, reset, step and register stimulus,
// result back-pressure and the verdict. Depends on mer_pkg, mer_if, the RTL top
// and ellipse_point_checker.
`timescale 1ns / 1ps

module testbench;
  import mer_pkg::*;

  localparam int ITEMS_PER_PHASE = 325;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_GAP       = 4;
  localparam int QUIET_LIMIT     = 2000;
  localparam int BIG_RADIUS      = 100;
  localparam int BIG_WALK_STEPS  = 40;

  logic clk;
  logic rst;
  int   hold_asked;
  int   idle_pct, stall_pct;
  int   items;
  int   last_seen;
  int   fail_count, points_due;
  int   rx_now, ry_now;

  mer_step_if   step_ch ();
  mer_result_if result_ch ();
  mer_cfg_if    cfg_ch ();

  midpoint_ellipse_rasterizer_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .step   (step_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  ellipse_point_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .step    (step_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .errors  (fail_count),
    .pending (points_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) last_seen <= 0;
    else if (result_ch.valid && result_ch.ready && result_ch.last) last_seen <= last_seen + 1;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_done;
    hold_left       = 0;
    hold_done       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((step_ch.valid && step_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("midpoint_ellipse_rasterizer_unit verification failed");
    $finish;
  end

  task automatic send_step(input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      step_ch.valid <= 1'b0;
      @(posedge clk);
    end
    step_ch.valid   <= 1'b1;
    step_ch.restart <= restart;
    do @(posedge clk); while (!step_ch.ready);
    items++;
  endtask

  // wait until every expected point is out, then let in-flight steps settle
  task automatic drain();
    step_ch.valid <= 1'b0;
    do @(negedge clk); while (points_due != 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_radius();
    int r;
    r = $urandom_range(99);
    if (r < 1) return CFG_DATA_W'($urandom);
    if (r < 2) return CFG_DATA_W'(1023);
    if (r < 7) return '0;
    if (r < 25) return CFG_DATA_W'($urandom_range(60, 13));
    return CFG_DATA_W'($urandom_range(12, 1));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_center();
    int r;
    r = $urandom_range(9);
    if (r == 0) return CFG_DATA_W'(16'h0400);
    if (r == 1) return CFG_DATA_W'(16'h03FF);
    return CFG_DATA_W'($urandom);
  endfunction

  task automatic write_random_cfg();
    logic [CFG_DATA_W-1:0] val;
    bit [3:0]              pick;
    pick = 4'($urandom_range(15, 1));
    // never keep a wide radius around for long
    if (pick[0] || rx_now > BIG_RADIUS) begin
      val    = pick_radius();
      rx_now = val[RADIUS_BITS_DEF-1:0];
      write_reg(REG_RADIUS_X, val);
    end
    if (pick[1] || ry_now > BIG_RADIUS) begin
      val    = pick_radius();
      ry_now = val[RADIUS_BITS_DEF-1:0];
      write_reg(REG_RADIUS_Y, val);
    end
    if (pick[2]) write_reg(REG_CENTER_X, pick_center());
    if (pick[3]) write_reg(REG_CENTER_Y, pick_center());
    cfg_ch.valid <= 1'b0;
  endtask

  // restart, then step until the final point shows up or stop_at steps went by;
  // cfg_at > 0 rewrites registers mid-walk after that many steps
  task automatic run_walk(input int stop_at, input int cfg_at);
    int base, n;
    base = last_seen;
    n    = 0;
    send_step(1'b1);
    while (last_seen == base && (stop_at == 0 || n < stop_at)) begin
      if (cfg_at != 0 && n == cfg_at) begin
        drain();
        write_random_cfg();
      end
      send_step(1'b0);
      n++;
    end
    repeat ($urandom_range(2)) send_step(1'b0);
  endtask

  task automatic directed_walks();
    // walk is idle out of reset, steps give nothing
    send_step(1'b0);
    send_step(1'b0);
    run_walk(0, 0);
    drain();
    // zero radii act as one; centers at both extremes
    write_reg(REG_RADIUS_X, '0);
    write_reg(REG_RADIUS_Y, '0);
    write_reg(REG_CENTER_X, CFG_DATA_W'(16'h03FF));
    write_reg(REG_CENTER_Y, CFG_DATA_W'(16'h0400));
    cfg_ch.valid <= 1'b0;
    run_walk(0, 0);
    drain();
    write_reg(REG_RADIUS_X, CFG_DATA_W'(1023));
    write_reg(REG_RADIUS_Y, CFG_DATA_W'(1023));
    write_reg(REG_CENTER_X, CFG_DATA_W'(16'h0400));
    write_reg(REG_CENTER_Y, CFG_DATA_W'(16'h03FF));
    cfg_ch.valid <= 1'b0;
    run_walk(3, 0);
    run_walk(2, 0);
    drain();
    // new radii must not touch the walk in progress
    write_reg(REG_RADIUS_X, CFG_DATA_W'(3));
    write_reg(REG_RADIUS_Y, CFG_DATA_W'(2));
    cfg_ch.valid <= 1'b0;
    rx_now = 3;
    ry_now = 2;
    send_step(1'b0);
    send_step(1'b0);
    run_walk(0, 0);
  endtask

  task automatic random_segment();
    int mode;
    int cap;
    drain();
    write_random_cfg();
    repeat ($urandom_range(4, 1)) begin
      // walks on a wide radius are cut short to keep the step count on target
      cap  = (rx_now > BIG_RADIUS || ry_now > BIG_RADIUS) ? BIG_WALK_STEPS : 0;
      mode = $urandom_range(99);
      if (mode < 70) run_walk(cap, 0);
      else if (mode < 80) run_walk($urandom_range(8, 1), 0);
      else if (mode < 88) run_walk(cap, $urandom_range(5, 1));
      else repeat ($urandom_range(6, 1)) send_step(1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst             = 1'b1;
    hold_asked      = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    items           = 0;
    rx_now          = 1;
    ry_now          = 1;
    step_ch.valid   = 1'b0;
    step_ch.restart = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_RADIUS_X;
    cfg_ch.data     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 48;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 48;
        end
        default: begin
          idle_pct  = 37;
          stall_pct = 37;
        end
      endcase
      if (ph == 0) directed_walks();
      // long result hold-off while steps keep coming
      hold_asked <= hold_asked + 1;
      while (items < (ph + 1) * ITEMS_PER_PHASE) random_segment();
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("midpoint_ellipse_rasterizer_unit verification clean");
    else
      $display("midpoint_ellipse_rasterizer_unit verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/mer_pkg.sv
rtl/mer_if.sv
rtl/mer_setup.sv
rtl/mer_step.sv
rtl/midpoint_ellipse_rasterizer_unit.sv
rtl/mer_checker.sv
test/ellipse_point_checker.sv
test/testbench.sv
